[hdl/tps_pkg.sv]
// Shared constants for the trapezoid pulse shaper.
package tps_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS = 32;
    localparam int INDEX_BITS = 2;

    localparam logic [INDEX_BITS-1:0] REG_PERIOD = 2'd0;
    localparam logic [INDEX_BITS-1:0] REG_WIDTH = 2'd1;
    localparam logic [INDEX_BITS-1:0] REG_RAMP = 2'd2;

    localparam logic [WORD_BITS-1:0] PERIOD_RESET = 32'd1000;
    localparam logic [WORD_BITS-1:0] WIDTH_RESET = 32'd500;
    localparam logic [WORD_BITS-1:0] RAMP_RESET = 32'd0;

endpackage

[hdl/tps_mod_cell.sv]
// One restoring step of the position-modulo-period chain.
module tps_mod_cell #(
    parameter int TIME_BITS = tps_pkg::TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [TIME_BITS-1:0] period,
    input  logic                 in_valid,
    input  logic [TIME_BITS-1:0] in_rem,
    input  logic [TIME_BITS-1:0] in_pos,
    output logic                 out_valid,
    output logic [TIME_BITS-1:0] out_rem,
    output logic [TIME_BITS-1:0] out_pos
);

    logic                 valid_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic [TIME_BITS-1:0] rem_next;
    logic [TIME_BITS-1:0] pos_reg;
    logic [TIME_BITS:0]   trial;

    // Bring in the next position bit and subtract the period if it fits.
    always_comb
    begin
        trial = {in_rem, in_pos[TIME_BITS-1]};
        if (trial >= {1'b0, period})
        begin
            trial = trial - {1'b0, period};
        end
        rem_next = trial[TIME_BITS-1:0];
    end

    // Control bit is reset; the payload only follows the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg <= rem_next;
            pos_reg <= {in_pos[TIME_BITS-2:0], 1'b0};
        end
    end

    assign out_valid = valid_reg;
    assign out_rem = rem_reg;
    assign out_pos = pos_reg;

endmodule

[hdl/tps_shape.sv]
// Picks the waveform segment for a phase and sets up the ramp quotient.
module tps_shape #(
    parameter int TIME_BITS = tps_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = tps_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [TIME_BITS-1:0] period,
    input  logic [TIME_BITS-1:0] width,
    input  logic [TIME_BITS-1:0] ramp,
    input  logic                 in_valid,
    input  logic [TIME_BITS-1:0] phase,
    output logic                 out_valid,
    output logic [TIME_BITS-1:0] out_rem,
    output logic [FRAC_BITS:0]   out_q,
    output logic                 out_done
);

    localparam logic [FRAC_BITS:0] LEVEL_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic                 valid_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic [TIME_BITS-1:0] rem_next;
    logic [FRAC_BITS:0]   q_reg;
    logic [FRAC_BITS:0]   q_next;
    logic                 done_reg;
    logic                 done_next;
    logic [TIME_BITS-1:0] fall_end;
    logic [TIME_BITS-1:0] fall_num;

    assign fall_end = width + ramp;
    assign fall_num = fall_end - phase;

    // The hard rectangle covers a zero period, a zero ramp and a full width.
    always_comb
    begin
        rem_next = phase;
        q_next = '0;
        done_next = 1'b1;
        if (period == '0 || ramp == '0 || width >= period)
        begin
            q_next = (phase < width) ? LEVEL_ONE : '0;
        end
        else if (phase < width)
        begin
            if (phase < ramp)
            begin
                done_next = 1'b0;
            end
            else
            begin
                q_next = LEVEL_ONE;
            end
        end
        else if (phase < fall_end)
        begin
            rem_next = fall_num;
            if (fall_num >= ramp)
            begin
                q_next = LEVEL_ONE;
            end
            else
            begin
                done_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg <= rem_next;
            q_reg <= q_next;
            done_reg <= done_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem = rem_reg;
    assign out_q = q_reg;
    assign out_done = done_reg;

endmodule

[hdl/tps_div_cell.sv]
// One fraction bit of the truncated ramp quotient.
module tps_div_cell #(
    parameter int TIME_BITS = tps_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = tps_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [TIME_BITS-1:0] den,
    input  logic                 in_valid,
    input  logic [TIME_BITS-1:0] in_rem,
    input  logic [FRAC_BITS:0]   in_q,
    input  logic                 in_done,
    output logic                 out_valid,
    output logic [TIME_BITS-1:0] out_rem,
    output logic [FRAC_BITS:0]   out_q,
    output logic                 out_done
);

    logic                 valid_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic [TIME_BITS-1:0] rem_next;
    logic [FRAC_BITS:0]   q_reg;
    logic [FRAC_BITS:0]   q_next;
    logic                 done_reg;
    logic [TIME_BITS:0]   trial;
    logic                 fits;

    // Words with a fixed level pass through untouched.
    always_comb
    begin
        trial = {in_rem, 1'b0};
        fits = (trial >= {1'b0, den});
        if (fits)
        begin
            trial = trial - {1'b0, den};
        end
        if (in_done)
        begin
            rem_next = in_rem;
            q_next = in_q;
        end
        else
        begin
            rem_next = trial[TIME_BITS-1:0];
            q_next = {in_q[FRAC_BITS-1:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg <= rem_next;
            q_reg <= q_next;
            done_reg <= in_done;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem = rem_reg;
    assign out_q = q_reg;
    assign out_done = done_reg;

endmodule

[hdl/trapezoid_pulse_shaper.sv]
// Top level of the trapezoid pulse shaper: registers and the cell chain.
//
//  Channel   Handshake             Payload
//  input     in_valid / in_ready   time_position[31:0]
//  output    out_valid / out_ready level[FRAC_BITS:0]
//  config    wr_en                 wr_index[1:0], wr_data[31:0]
//
// One word enters per clock unless the chain holds; the chain is one modulo
// cell per position bit, then the segment stage, then one divide cell per
// fraction bit. The whole chain moves together: it holds when the last word
// is not taken, and in_ready follows that. Reset empties the chain and loads
// the register defaults.
module trapezoid_pulse_shaper #(
    parameter int TIME_BITS = tps_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = tps_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tps_pkg::WORD_BITS-1:0]       time_position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [FRAC_BITS:0]                  level,
    input  logic                                wr_en,
    input  logic [tps_pkg::INDEX_BITS-1:0]      wr_index,
    input  logic [tps_pkg::WORD_BITS-1:0]       wr_data
);

    logic [TIME_BITS-1:0] period_reg;
    logic [TIME_BITS-1:0] width_reg;
    logic [TIME_BITS-1:0] ramp_reg;
    logic [TIME_BITS-1:0] ramp_clamped;
    logic [TIME_BITS-1:0] gap;
    logic                 advance;

    logic                 mod_valid [0:TIME_BITS];
    logic [TIME_BITS-1:0] mod_rem [0:TIME_BITS];
    logic [TIME_BITS-1:0] mod_pos [0:TIME_BITS];

    logic                 div_valid [0:FRAC_BITS];
    logic [TIME_BITS-1:0] div_rem [0:FRAC_BITS];
    logic [FRAC_BITS:0]   div_q [0:FRAC_BITS];
    logic                 div_done [0:FRAC_BITS];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= TIME_BITS'(tps_pkg::PERIOD_RESET);
            width_reg <= TIME_BITS'(tps_pkg::WIDTH_RESET);
            ramp_reg <= TIME_BITS'(tps_pkg::RAMP_RESET);
        end
        else if (wr_en)
        begin
            case (wr_index)
                tps_pkg::REG_PERIOD: period_reg <= TIME_BITS'(wr_data);
                tps_pkg::REG_WIDTH:  width_reg <= TIME_BITS'(wr_data);
                tps_pkg::REG_RAMP:   ramp_reg <= TIME_BITS'(wr_data);
                default:             ;
            endcase
        end
    end

    // Ramp limited to the high time and to the low time of the period.
    assign gap = period_reg - width_reg;
    always_comb
    begin
        ramp_clamped = ramp_reg;
        if (ramp_clamped > width_reg)
        begin
            ramp_clamped = width_reg;
        end
        if (width_reg < period_reg && ramp_clamped > gap)
        begin
            ramp_clamped = gap;
        end
    end

    // The chain moves unless a finished word is waiting and not taken.
    assign advance = !div_valid[FRAC_BITS] || out_ready;
    assign in_ready = advance;

    assign mod_valid[0] = in_valid;
    assign mod_rem[0] = '0;
    assign mod_pos[0] = TIME_BITS'(time_position);

    // Phase = position modulo period, one bit per cell.
    for (genvar i = 0; i < TIME_BITS; i++)
    begin : g_mod
        tps_mod_cell #(
            .TIME_BITS(TIME_BITS)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .advance(advance),
            .period(period_reg),
            .in_valid(mod_valid[i]),
            .in_rem(mod_rem[i]),
            .in_pos(mod_pos[i]),
            .out_valid(mod_valid[i+1]),
            .out_rem(mod_rem[i+1]),
            .out_pos(mod_pos[i+1])
        );
    end

    tps_shape #(
        .TIME_BITS(TIME_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_shape (
        .clk(clk),
        .rst_n(rst_n),
        .advance(advance),
        .period(period_reg),
        .width(width_reg),
        .ramp(ramp_clamped),
        .in_valid(mod_valid[TIME_BITS] && mod_pos[TIME_BITS] == '0),
        .phase(mod_rem[TIME_BITS]),
        .out_valid(div_valid[0]),
        .out_rem(div_rem[0]),
        .out_q(div_q[0]),
        .out_done(div_done[0])
    );

    // Ramp quotient, one fraction bit per cell.
    for (genvar j = 0; j < FRAC_BITS; j++)
    begin : g_div
        tps_div_cell #(
            .TIME_BITS(TIME_BITS),
            .FRAC_BITS(FRAC_BITS)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .advance(advance),
            .den(ramp_clamped),
            .in_valid(div_valid[j]),
            .in_rem(div_rem[j]),
            .in_q(div_q[j]),
            .in_done(div_done[j]),
            .out_valid(div_valid[j+1]),
            .out_rem(div_rem[j+1]),
            .out_q(div_q[j+1]),
            .out_done(div_done[j+1])
        );
    end

    assign out_valid = div_valid[FRAC_BITS];
    assign level = div_q[FRAC_BITS];

endmodule
